// File: design/crcfr_pkg.sv
`timescale 1ns / 1ps
package crcfr_pkg;

  // frame length counters never go past the result limit
  localparam int MAX_RESULTS      = 32;
  localparam int CNT_W            = $clog2(MAX_RESULTS + 1);
  localparam int BUFFER_BYTES_DEF = 32;

  // configuration port
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;
  localparam int FRAME_LIMIT_W  = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT  = 1'b1;
  localparam logic [15:0]              IDLE_TIMEOUT_RST = 16'd50;
  localparam logic [FRAME_LIMIT_W-1:0] FRAME_LIMIT_RST  = 6'd32;

  // crc-16/modbus
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // result kinds
  localparam logic [1:0] ST_BYTE = 2'd0;
  localparam logic [1:0] ST_LAST = 2'd1;
  localparam logic [1:0] ST_DROP = 2'd2;

  // heater frame layout
  localparam logic [7:0] HEATER_ID         = 8'h04;
  localparam logic [7:0] CMD_SETTINGS_A    = 8'h01;
  localparam logic [7:0] CMD_SETTINGS_B    = 8'h02;
  localparam logic [7:0] CMD_HEATER_REPORT = 8'h0F;
  localparam logic [7:0] CMD_PANEL         = 8'h11;
  localparam logic [CNT_W-1:0] MIN_HEATER_LEN   = CNT_W'(7);
  localparam logic [CNT_W-1:0] MIN_SETTINGS_LEN = CNT_W'(13);
  localparam logic [CNT_W-1:0] MIN_STATUS_LEN   = CNT_W'(17);
  localparam logic [CNT_W-1:0] MIN_PANEL_LEN    = CNT_W'(8);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic             accept;     // input word taken this cycle
    logic             flush_clear; // frame consumed, restart collection
    logic             apply;      // good frame, update heater status
    logic             load_drop;  // load a dropped result
    logic             load_byte;  // load the prefetched byte as a result
    logic             last;       // loaded byte is the last of the frame
    logic             rd_en;      // prefetch a stored byte
    logic [CNT_W-1:0] rd_addr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             flush_req;  // last word ended the frame
    logic             crc_good;
    logic             out_free;   // output register can take a result
    logic [CNT_W-1:0] count;
  } sts_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: design/crcfr_datapath.sv
`timescale 1ns / 1ps
module crcfr_datapath #(
  parameter int BUFFER_BYTES = crcfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [crcfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crcfr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]                     s_tdata,
  input  logic                           s_tuser,
  input  logic                           m_tready,
  input  crcfr_pkg::cmd_t                cmd,
  output crcfr_pkg::sts_t                sts,
  output logic                           m_tvalid,
  output logic [95:0]                    m_tdata,
  output logic [1:0]                     m_tuser
);
  import crcfr_pkg::*;

  localparam int LIMIT  = (BUFFER_BYTES < MAX_RESULTS) ? BUFFER_BYTES : MAX_RESULTS;
  localparam int ADDR_W = $clog2(BUFFER_BYTES);

  logic [7:0] mem [BUFFER_BYTES];
  logic [7:0] rd_data;

  logic [15:0]              idle_timeout;
  logic [FRAME_LIMIT_W-1:0] frame_limit;
  logic [CNT_W-1:0]         count;
  logic [15:0]              idle;
  logic                     flush_req;
  logic [15:0]              crc;
  logic [7:0]               hist0, hist1;
  logic [7:0] b1, b4, b5, b7, b8, b9, b10, b11, b14;

  logic [7:0]  mode_reg, setpoint_reg, vent_reg, power_reg;
  logic [7:0]  heater_temp_reg, external_temp_reg, run_state_reg, panel_temp_reg;
  logic [15:0] battery_reg;
  logic        changed;

  logic [7:0] out_byte;
  logic [1:0] out_status;
  logic       out_changed;

  logic [CNT_W-1:0] lim, count_inc, count_after;
  logic [15:0]      idle_inc, to;
  logic             store;

  logic [7:0]  mode_next, setpoint_next, vent_next, power_next;
  logic [7:0]  heater_temp_next, external_temp_next, run_state_next, panel_temp_next;
  logic [15:0] battery_next;
  logic        changed_next;

  always_comb begin
    if (frame_limit > FRAME_LIMIT_W'(LIMIT)) begin
      lim = CNT_W'(LIMIT);
    end else if (frame_limit == '0) begin
      lim = CNT_W'(1);
    end else begin
      lim = CNT_W'(frame_limit);
    end
  end

  assign store       = cmd.accept && !s_tuser && (count < lim);
  assign count_inc   = count + CNT_W'(1);
  assign count_after = store ? count_inc : count;
  assign idle_inc    = (idle != 16'hFFFF) ? idle + 16'd1 : idle;
  assign to          = (idle_timeout == '0) ? 16'd1 : idle_timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= IDLE_TIMEOUT_RST;
      frame_limit  <= FRAME_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDLE_TIMEOUT: idle_timeout <= cfg_data;
        CFG_FRAME_LIMIT:  frame_limit  <= cfg_data[FRAME_LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // collection: count, idle timer, crc lagging two bytes behind the write pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idle      <= '0;
      flush_req <= 1'b0;
      crc       <= CRC_INIT;
    end else if (cmd.flush_clear) begin
      count     <= '0;
      idle      <= '0;
      flush_req <= 1'b0;
      crc       <= CRC_INIT;
    end else if (cmd.accept) begin
      if (!s_tuser) begin
        idle      <= '0;
        count     <= count_after;
        flush_req <= (count_after >= lim);
        if (store && count >= CNT_W'(2)) begin
          crc <= crc_byte(crc, hist1);
        end
      end else if (count != '0) begin
        idle      <= idle_inc;
        flush_req <= (idle_inc >= to);
      end else begin
        flush_req <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      hist1 <= hist0;
      hist0 <= s_tdata;
      unique case (count)
        CNT_W'(1):  b1  <= s_tdata;
        CNT_W'(4):  b4  <= s_tdata;
        CNT_W'(5):  b5  <= s_tdata;
        CNT_W'(7):  b7  <= s_tdata;
        CNT_W'(8):  b8  <= s_tdata;
        CNT_W'(9):  b9  <= s_tdata;
        CNT_W'(10): b10 <= s_tdata;
        CNT_W'(11): b11 <= s_tdata;
        CNT_W'(14): b14 <= s_tdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem[count[ADDR_W-1:0]] <= s_tdata;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr[ADDR_W-1:0]];
    end
  end

  // heater status decode
  always_comb begin
    mode_next          = mode_reg;
    setpoint_next      = setpoint_reg;
    vent_next          = vent_reg;
    power_next         = power_reg;
    heater_temp_next   = heater_temp_reg;
    external_temp_next = external_temp_reg;
    battery_next       = battery_reg;
    run_state_next     = run_state_reg;
    panel_temp_next    = panel_temp_reg;
    changed_next       = 1'b0;
    if (count >= MIN_HEATER_LEN && b1 == HEATER_ID) begin
      unique case (b4)
        CMD_SETTINGS_A, CMD_SETTINGS_B: begin
          if (count >= MIN_SETTINGS_LEN) begin
            mode_next     = b7;
            setpoint_next = b8;
            vent_next     = b9;
            power_next    = b10;
            changed_next  = (b7 != mode_reg) || (b8 != setpoint_reg) ||
                            (b9 != vent_reg) || (b10 != power_reg);
          end
        end
        CMD_HEATER_REPORT: begin
          if (count >= MIN_STATUS_LEN) begin
            heater_temp_next   = b8;
            external_temp_next = b9;
            battery_next       = {b10, b11};
            run_state_next     = b14;
            changed_next       = (b14 != run_state_reg);
          end
        end
        CMD_PANEL: begin
          if (count >= MIN_PANEL_LEN) begin
            panel_temp_next = b5;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg          <= '0;
      setpoint_reg      <= '0;
      vent_reg          <= '0;
      power_reg         <= '0;
      heater_temp_reg   <= '0;
      external_temp_reg <= '0;
      battery_reg       <= '0;
      run_state_reg     <= '0;
      panel_temp_reg    <= '0;
    end else if (cmd.apply) begin
      mode_reg          <= mode_next;
      setpoint_reg      <= setpoint_next;
      vent_reg          <= vent_next;
      power_reg         <= power_next;
      heater_temp_reg   <= heater_temp_next;
      external_temp_reg <= external_temp_next;
      battery_reg       <= battery_next;
      run_state_reg     <= run_state_next;
      panel_temp_reg    <= panel_temp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      changed <= changed_next;
    end
  end

  // output register; status registers only move while it is free
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_drop || cmd.load_byte) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_drop) begin
      out_byte    <= '0;
      out_status  <= ST_DROP;
      out_changed <= 1'b0;
    end else if (cmd.load_byte) begin
      out_byte    <= rd_data;
      out_status  <= cmd.last ? ST_LAST : ST_BYTE;
      out_changed <= changed;
    end
  end

  assign m_tdata = {7'd0, panel_temp_reg, run_state_reg, battery_reg, external_temp_reg,
                    heater_temp_reg, power_reg, vent_reg, setpoint_reg, mode_reg,
                    out_changed, out_byte};
  assign m_tuser = out_status;

  assign sts.flush_req = flush_req;
  assign sts.crc_good  = (count >= CNT_W'(2)) && (crc == {hist1, hist0});
  assign sts.out_free  = !m_tvalid || m_tready;
  assign sts.count     = count;

endmodule

// File: design/crcfr_ctrl.sv
`timescale 1ns / 1ps
module crcfr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  crcfr_pkg::sts_t sts,
  output crcfr_pkg::cmd_t cmd
);
  import crcfr_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] frame_len;
  logic [CNT_W-1:0] rd_ptr;
  logic [CNT_W-1:0] emit_idx;
  logic             dv;

  logic emit_load, emit_rd, emit_last;

  assign emit_load = (state == ST_EMIT) && dv && sts.out_free;
  assign emit_rd   = (state == ST_EMIT) && (rd_ptr < frame_len) && (!dv || emit_load);
  assign emit_last = (emit_idx == frame_len - CNT_W'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!sts.flush_req) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          state_next = sts.crc_good ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_load && emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    s_tready    = 1'b0;
    cmd.rd_addr = rd_ptr;
    unique case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_DECIDE: begin
        if (sts.flush_req && sts.out_free) begin
          cmd.flush_clear = 1'b1;
          cmd.apply       = sts.crc_good;
          cmd.load_drop   = !sts.crc_good;
        end
      end
      ST_EMIT: begin
        cmd.rd_en     = emit_rd;
        cmd.load_byte = emit_load;
        cmd.last      = emit_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // one byte prefetch ahead of the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_len <= '0;
      rd_ptr    <= '0;
      emit_idx  <= '0;
      dv        <= 1'b0;
    end else if (state == ST_DECIDE && cmd.apply) begin
      frame_len <= sts.count;
      rd_ptr    <= '0;
      emit_idx  <= '0;
      dv        <= 1'b0;
    end else if (state == ST_EMIT) begin
      if (emit_rd) rd_ptr <= rd_ptr + CNT_W'(1);
      if (emit_load) emit_idx <= emit_idx + CNT_W'(1);
      dv <= emit_rd || (dv && !emit_load);
    end
  end

  a_emit_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> frame_len >= CNT_W'(2))
    else $error("emitting a frame shorter than its check value");

  a_prefetch: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> rd_ptr == emit_idx + CNT_W'(dv))
    else $error("prefetch pointer out of step with emitted bytes");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.load_byte |-> emit_idx < frame_len)
    else $error("byte emitted past the end of the frame");

  a_apply_once: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> state == ST_EMIT && !cmd.apply)
    else $error("status update not followed by frame emission");

endmodule

// File: design/crc_checked_frame_relay_parser.sv
`timescale 1ns / 1ps
// serial frame relay with crc-16/modbus check and heater status capture
// input stream: one word per received byte (s_tuser 0) or per millisecond tick (s_tuser 1)
// bytes collect in a frame buffer; a frame ends when idle ticks reach idle_timeout or
// when the byte count reaches frame_limit
// output stream: a good frame comes out byte by byte (m_tuser 0, last byte 1), a bad or
// one-byte frame gives a single dropped word (m_tuser 2); every word carries the heater
// status registers as they stand after that frame
// config: cfg_we writes cfg_data to register cfg_index (0 idle_timeout, 1 frame_limit);
// the user must write it only while the block is idle; the block does not enforce this
// timing: an input word is accepted, then the end-of-frame decision is made; as each
// byte is stored the datapath folds the byte two places back into the crc; after a
// good frame end, results come one per cycle while the receiver is ready, from a
// one-byte prefetch out of the frame buffer's registered read port
// input is refused while a frame is being emitted
// a stalled receiver holds the output register and the emission waits; status
// registers only update while the output register is free
// reset clears counters, status registers and config to their defaults; buffer
// contents are left as they are
module crc_checked_frame_relay_parser #(
  parameter int BUFFER_BYTES = crcfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // rx_byte
  input  logic                             s_tuser,   // op
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_byte, changed, mode_now, setpoint_now, vent_now, power_now, heater_temp_now,
  // external_temp_now, battery_now, run_state_now, panel_temp_now, zero pad
  output logic [95:0]                      m_tdata,
  output logic [1:0]                       m_tuser,   // status
  input  logic                             cfg_we,
  input  logic [crcfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crcfr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import crcfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing: accept, decide on frame end, emit
  crcfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // frame buffer, crc, status registers and output register
  crcfr_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
